// ===== rtl/core/gwd_pkg.sv =====
// ----------------------------------------------------------------------------
// gwd_pkg
// Shared sizes, types and the range window rule for the wavefront distance map.
// ----------------------------------------------------------------------------
package gwd_pkg;

  localparam int GRID_ROWS = 32;
  localparam int GRID_COLS = 32;
  localparam int NTILES    = GRID_ROWS * GRID_COLS;
  localparam int IDX_W     = $clog2(NTILES);
  localparam int SWP_W     = $clog2(NTILES + 1);

  localparam int TILE_W    = 10;
  localparam int COST_W    = 11;
  localparam int MIN_W     = 10;
  localparam int COUNT_W   = 11;

  localparam logic signed [COST_W-1:0] COST_NONE = '1;
  localparam logic [COUNT_W-1:0]       COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // request to the range counter
  typedef struct packed {
    logic                     clear;
    logic                     add;
    logic signed [COST_W-1:0] cost;
  } cnt_ctl_t;

  // origin counts only when min is zero; max of minus one admits every reached tile
  function automatic logic in_window(logic signed [COST_W-1:0] d,
                                     logic [MIN_W-1:0] mn,
                                     logic signed [COST_W-1:0] mx);
    logic r;
    if (d == '0) begin
      r = (mn == '0);
    end else if (d < 0) begin
      r = 1'b0;
    end else if (mx == COST_NONE) begin
      r = 1'b1;
    end else begin
      r = (d <= mx) && (d >= $signed({1'b0, mn}));
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/gwd_count.sv =====
// ----------------------------------------------------------------------------
// gwd_count
// Saturating count of tiles whose cost falls inside the range window.
// ----------------------------------------------------------------------------
module gwd_count
  import gwd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cnt_ctl_t                 ctl,
  input  logic [MIN_W-1:0]         min_range,
  input  logic signed [COST_W-1:0] max_range,
  output logic [COUNT_W-1:0]       count
);

  logic hit;

  assign hit = ctl.add && in_window(ctl.cost, min_range, max_range);

  // restart on clear, otherwise add each newly costed tile in the window
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.clear) begin
      count <= hit ? COUNT_W'(1) : '0;
    end else if (hit && count != COUNT_MAX) begin
      count <= count + COUNT_W'(1);
    end
  end

endmodule

// ===== rtl/core/grid_wavefront_distance_map.sv =====
// ----------------------------------------------------------------------------
// grid_wavefront_distance_map
// Breadth-first layer distance map over a walled tile grid.
// ----------------------------------------------------------------------------
// Wall writes, unused codes and requests naming a tile outside the grid are
// answered straight from the request; a tile read waits for one cost memory
// read. After reset the block runs a clearing pass over every tile before it
// takes a request. A run sweeps the cost memory back to unreached, seeds the
// origin, then for each tile taken off the wave queue reads its cost and wall
// bit and, for a floor tile, tests each neighbour in turn, costing and queueing
// every unreached in-grid one; it answers once the queue runs empty.
// ----------------------------------------------------------------------------
module grid_wavefront_distance_map
  import gwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] operation, [11:2] tile_index, [12] is_wall, [23:13] max_range,
  // [33:24] min_range, [39:34] zero
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [10:0] cost, [11] in_range, [22:12] range_count, [23] zero
  output logic [23:0] m_tdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_ORIGIN, S_POP, S_TILE, S_EXPAND, S_NBR, S_NBWR
  } state_t;

  // request fields
  op_t                     operation;
  logic [TILE_W-1:0]       tile_index;
  logic                    is_wall;
  logic signed [COST_W-1:0] max_range;
  logic [MIN_W-1:0]        min_range;
  logic                    accept;
  logic                    idx_ok;
  logic [IDX_W-1:0]        idx;

  assign operation  = op_t'(s_tdata[1:0]);
  assign tile_index = s_tdata[11:2];
  assign is_wall    = s_tdata[12];
  assign max_range  = $signed(s_tdata[23:13]);
  assign min_range  = s_tdata[33:24];
  assign accept     = s_tvalid && s_tready;
  assign idx_ok     = int'(tile_index) < NTILES;
  assign idx        = IDX_W'(tile_index);

  // sequencer registers
  state_t                   state;
  logic                     init;
  logic                     reading;
  logic [SWP_W-1:0]         sweep;
  logic [IDX_W-1:0]         origin;
  logic [SWP_W-1:0]         head;
  logic [SWP_W-1:0]         tail;
  logic [IDX_W-1:0]         tile;
  logic signed [COST_W-1:0] tile_d;
  logic [1:0]               nbr_k;
  logic [IDX_W-1:0]         nbr;
  logic [MIN_W-1:0]         last_min;
  logic signed [COST_W-1:0] last_max;

  // output register
  logic                     out_valid;
  logic signed [COST_W-1:0] out_cost;
  logic                     out_flag;
  logic [COUNT_W-1:0]       out_count;

  // answers that need no memory read
  logic                     done;
  logic signed [COST_W-1:0] done_cost;
  logic [COUNT_W-1:0]       done_count;

  // memories and their ports
  logic                     wall_mem [NTILES];
  logic [COST_W-1:0]        cost_mem [NTILES];
  logic [IDX_W-1:0]         queue_mem [NTILES];

  logic                     wall_we, wall_wd, wall_rd;
  logic [IDX_W-1:0]         wall_wa, wall_ra;
  logic                     cost_we;
  logic [IDX_W-1:0]         cost_wa, cost_ra;
  logic signed [COST_W-1:0] cost_wd, cost_rd;
  logic                     q_we;
  logic [IDX_W-1:0]         q_wa, q_ra, q_wd, q_rd;

  // neighbour selection
  logic [IDX_W-1:0]         row, col;
  logic                     nbr_ok;
  logic [IDX_W-1:0]         nbr_addr;
  logic                     last_nbr;

  cnt_ctl_t                 cnt_ctl;
  logic [COUNT_W-1:0]       count;

  assign s_tready = (state == S_IDLE) && !reading && (!out_valid || m_tready);
  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_count, out_flag, out_cost};

  assign row      = tile / IDX_W'(GRID_COLS);
  assign col      = tile % IDX_W'(GRID_COLS);
  assign last_nbr = (nbr_k == 2'd3);

  // pick the neighbour under test: up, down, left, right
  always_comb begin
    nbr_ok   = 1'b0;
    nbr_addr = tile;
    case (nbr_k)
      2'd0: begin
        nbr_ok   = (row != '0);
        nbr_addr = tile - IDX_W'(GRID_COLS);
      end
      2'd1: begin
        nbr_ok   = (int'(row) + 1 < GRID_ROWS);
        nbr_addr = tile + IDX_W'(GRID_COLS);
      end
      2'd2: begin
        nbr_ok   = (col != '0);
        nbr_addr = tile - IDX_W'(1);
      end
      default: begin
        nbr_ok   = (int'(col) + 1 < GRID_COLS);
        nbr_addr = tile + IDX_W'(1);
      end
    endcase
  end

  // answer writes, unused codes, off-grid requests and finished runs
  always_comb begin
    done       = 1'b0;
    done_cost  = '0;
    done_count = '0;
    if (state == S_IDLE && accept) begin
      done = !(idx_ok && (operation == OP_RUN || operation == OP_READ));
      if (operation == OP_READ) begin
        done_cost = COST_NONE;
      end
    end else if (state == S_POP && head == tail) begin
      done       = 1'b1;
      done_count = count;
    end
  end

  // memory port steering
  always_comb begin
    wall_we = 1'b0;
    wall_wa = idx;
    wall_wd = is_wall;
    wall_ra = q_rd;
    cost_we = 1'b0;
    cost_wa = sweep[IDX_W-1:0];
    cost_wd = COST_NONE;
    cost_ra = idx;
    q_we    = 1'b0;
    q_wa    = tail[IDX_W-1:0];
    q_wd    = nbr;
    q_ra    = head[IDX_W-1:0];
    cnt_ctl = '{clear: 1'b0, add: 1'b0, cost: tile_d};
    unique case (state)
      S_IDLE: begin
        wall_we = accept && operation == OP_WRITE && idx_ok;
      end
      S_CLEAR: begin
        cost_we = 1'b1;
        wall_we = init;
        wall_wa = sweep[IDX_W-1:0];
        wall_wd = 1'b0;
      end
      S_ORIGIN: begin
        cost_we = 1'b1;
        cost_wa = origin;
        cost_wd = '0;
        q_we    = 1'b1;
        q_wa    = '0;
        q_wd    = origin;
        cnt_ctl = '{clear: 1'b1, add: 1'b1, cost: '0};
      end
      S_TILE: begin
        cost_ra = q_rd;
      end
      S_NBR: begin
        cost_ra = nbr_addr;
      end
      S_NBWR: begin
        cost_we = (cost_rd == COST_NONE);
        cost_wa = nbr;
        cost_wd = tile_d;
        q_we    = cost_we;
        cnt_ctl = '{clear: 1'b0, add: cost_we, cost: tile_d};
      end
      default: begin
      end
    endcase
  end

  // wall map
  always_ff @(posedge clk) begin
    if (wall_we) begin
      wall_mem[wall_wa] <= wall_wd;
    end
    wall_rd <= wall_mem[wall_ra];
  end

  // cost map
  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[cost_wa] <= cost_wd;
    end
    cost_rd <= $signed(cost_mem[cost_ra]);
  end

  // wave queue
  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_wa] <= q_wd;
    end
    q_rd <= queue_mem[q_ra];
  end

  gwd_count u_count (
    .clk       (clk),
    .rst       (rst),
    .ctl       (cnt_ctl),
    .min_range (last_min),
    .max_range (last_max),
    .count     (count)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      init      <= 1'b1;
      reading   <= 1'b0;
      sweep     <= '0;
      head      <= '0;
      tail      <= '0;
      nbr_k     <= '0;
      last_min  <= '0;
      last_max  <= COST_NONE;
      out_valid <= 1'b0;
    end else begin
      reading <= (state == S_IDLE) && accept && operation == OP_READ && idx_ok;

      // load a new answer, a tile read in the cycle after its request; drop once taken
      if (reading) begin
        out_valid <= 1'b1;
        out_cost  <= cost_rd;
        out_flag  <= in_window(cost_rd, last_min, last_max);
        out_count <= '0;
      end else if (done) begin
        out_valid <= 1'b1;
        out_cost  <= done_cost;
        out_flag  <= 1'b0;
        out_count <= done_count;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept && operation == OP_RUN && idx_ok) begin
            last_min <= min_range;
            last_max <= max_range;
            origin   <= idx;
            sweep    <= '0;
            state    <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          sweep <= sweep + SWP_W'(1);
          if (sweep == SWP_W'(NTILES - 1)) begin
            if (init) begin
              init  <= 1'b0;
              state <= S_IDLE;
            end else begin
              state <= S_ORIGIN;
            end
          end
        end
        S_ORIGIN: begin
          head  <= '0;
          tail  <= SWP_W'(1);
          state <= S_POP;
        end
        S_POP: begin
          if (head == tail) begin
            state <= S_IDLE;
          end else begin
            head  <= head + SWP_W'(1);
            state <= S_TILE;
          end
        end
        S_TILE: begin
          tile  <= q_rd;
          state <= S_EXPAND;
        end
        S_EXPAND: begin
          tile_d <= cost_rd + COST_W'(1);
          nbr_k  <= '0;
          state  <= wall_rd ? S_POP : S_NBR;
        end
        S_NBR: begin
          nbr <= nbr_addr;
          if (nbr_ok) begin
            state <= S_NBWR;
          end else if (last_nbr) begin
            state <= S_POP;
          end else begin
            nbr_k <= nbr_k + 2'd1;
          end
        end
        S_NBWR: begin
          if (q_we) begin
            tail <= tail + SWP_W'(1);
          end
          nbr_k <= nbr_k + 2'd1;
          state <= last_nbr ? S_POP : S_NBR;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // queue pointers stay ordered and within the queue
  assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("wave queue head passed tail");
  assert property (@(posedge clk) disable iff (rst) int'(tail) <= NTILES)
    else $error("wave queue overflow");
  // a run with an in-grid origin starts by clearing the cost map
  assert property (@(posedge clk) disable iff (rst)
    accept && operation == OP_RUN && idx_ok |=> state == S_CLEAR && !s_tready)
    else $error("run request did not start a clearing sweep");
  // every enqueued tile was unreached before being costed
  assert property (@(posedge clk) disable iff (rst)
    q_we && state == S_NBWR |-> cost_rd == COST_NONE)
    else $error("tile enqueued twice");

endmodule

// ===== verif/grid_wavefront_distance_map_chk.sv =====
// ----------------------------------------------------------------------------
// grid_wavefront_distance_map_chk
// Watches both stream channels of the distance map, keeps its own wall and
// cost maps, floods the grid on every run request and compares each answer
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module grid_wavefront_distance_map_chk
  import gwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // [1:0] operation, [11:2] tile_index, [12] is_wall, [23:13] max_range,
  // [33:24] min_range, [39:34] zero
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // [10:0] cost, [11] in_range, [22:12] range_count, [23] zero
  input  logic [23:0] m_tdata,
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [COST_W-1:0] cost;
    logic                     in_range;
    logic [COUNT_W-1:0]       range_count;
  } tile_answer_t;

  logic                     wall_map_q [NTILES];
  logic signed [COST_W-1:0] cost_map_q [NTILES];
  logic [MIN_W-1:0]         win_min_q;
  logic signed [COST_W-1:0] win_max_q;
  tile_answer_t             answers_q [$];
  int                       fails;

  function automatic logic tile_in_window(logic signed [COST_W-1:0] d,
                                          logic [MIN_W-1:0] mn,
                                          logic signed [COST_W-1:0] mx);
    if (d == 0) return mn == 0;
    if (d < 0) return 1'b0;
    if (mx == -1) return 1'b1;
    return (int'(d) <= int'(mx)) && (int'(d) >= int'(mn));
  endfunction

  // flood from the origin layer by layer and count tiles in the window
  function automatic logic [COUNT_W-1:0] flood_and_count(int origin,
                                                         logic [MIN_W-1:0] mn,
                                                         logic signed [COST_W-1:0] mx);
    int wave [$];
    int t, r, c, nb, k, cnt;
    logic signed [COST_W-1:0] nd;
    for (int i = 0; i < NTILES; i++) cost_map_q[i] = '1;
    cost_map_q[origin] = '0;
    wave.push_back(origin);
    while (wave.size() > 0) begin
      t  = wave.pop_front();
      r  = t / GRID_COLS;
      c  = t % GRID_COLS;
      nd = COST_W'(cost_map_q[t] + 1);
      if (!wall_map_q[t]) begin
        for (k = 0; k < 4; k++) begin
          nb = -1;
          case (k)
            0: if (r > 0) nb = t - GRID_COLS;
            1: if (r + 1 < GRID_ROWS) nb = t + GRID_COLS;
            2: if (c > 0) nb = t - 1;
            default: if (c + 1 < GRID_COLS) nb = t + 1;
          endcase
          if (nb >= 0 && cost_map_q[nb] == -1) begin
            cost_map_q[nb] = nd;
            wave.push_back(nb);
          end
        end
      end
    end
    cnt = 0;
    for (int i = 0; i < NTILES; i++)
      if (tile_in_window(cost_map_q[i], mn, mx)) cnt++;
    return (cnt > COUNT_MAX) ? COUNT_MAX : cnt[COUNT_W-1:0];
  endfunction

  always @(posedge clk) begin
    op_t                      op;
    int                       tile;
    logic [MIN_W-1:0]         mn;
    logic signed [COST_W-1:0] mx;
    tile_answer_t             ans, got;
    if (rst) begin
      for (int i = 0; i < NTILES; i++) begin
        wall_map_q[i] = 1'b0;
        cost_map_q[i] = '1;
      end
      win_min_q = '0;
      win_max_q = '1;
      answers_q.delete();
      fails = 0;
    end else begin
      // predict the answer to each accepted request
      if (s_tvalid && s_tready) begin
        op   = op_t'(s_tdata[1:0]);
        tile = int'(s_tdata[11:2]);
        mx   = s_tdata[23:13];
        mn   = s_tdata[33:24];
        ans  = '0;
        case (op)
          OP_WRITE: if (tile < NTILES) wall_map_q[tile] = s_tdata[12];
          OP_RUN: begin
            if (tile < NTILES) begin
              win_min_q = mn;
              win_max_q = mx;
              ans.range_count = flood_and_count(tile, mn, mx);
            end
          end
          OP_READ: begin
            if (tile < NTILES) begin
              ans.cost     = cost_map_q[tile];
              ans.in_range = tile_in_window(ans.cost, win_min_q, win_max_q);
            end else begin
              ans.cost = '1;
            end
          end
          default: ;
        endcase
        answers_q.push_back(ans);
      end
      // compare each answer with the oldest prediction
      if (m_tvalid && m_tready) begin
        got = {m_tdata[10:0], m_tdata[11], m_tdata[22:12]};
        if (answers_q.size() == 0) begin
          $error("answer with no request outstanding: %h", m_tdata);
          fails++;
        end else begin
          ans = answers_q.pop_front();
          if (got.cost !== ans.cost) begin
            $error("cost expected %0d actual %0d", ans.cost, got.cost);
            fails++;
          end
          if (got.in_range !== ans.in_range) begin
            $error("in_range expected %0d actual %0d", ans.in_range, got.in_range);
            fails++;
          end
          if (got.range_count !== ans.range_count) begin
            $error("range_count expected %0d actual %0d",
                   ans.range_count, got.range_count);
            fails++;
          end
        end
      end
    end
    fail_count  <= fails;
    outstanding <= answers_q.size();
  end

endmodule

// ===== verif/grid_wavefront_distance_map_tb.sv =====
// ----------------------------------------------------------------------------
// grid_wavefront_distance_map_tb
// Drives wall loads, flood runs and tile reads into the distance map: a short
// directed set, then random wall patterns each followed by runs and reads,
// under three idling mixes, with a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
module grid_wavefront_distance_map_tb;
  import gwd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  int          fail_count;
  int          outstanding;
  int          snd_idle = 0;
  int          rcv_idle = 0;
  logic        hold_req = 1'b0;
  int          sent = 0;

  always #2 clk = ~clk;

  grid_wavefront_distance_map u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  grid_wavefront_distance_map_chk u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  // offer one request, with random gaps ahead of it
  task automatic send(op_t op, int tile, int wall, int mx, int mn);
    while ($urandom_range(0, 99) < snd_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, mn[MIN_W-1:0], mx[COST_W-1:0], wall[0], tile[TILE_W-1:0], op};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic int pick_max();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) return -1;
    if (sel < 85) return $urandom_range(0, 70);
    return $urandom_range(0, 1023);
  endfunction

  function automatic int pick_min();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) return 0;
    if (sel < 85) return $urandom_range(0, 40);
    return $urandom_range(0, 1023);
  endfunction

  // one wall pattern, then runs and reads over it, with some noise
  task automatic random_segment();
    int dens, n, origin;
    dens = $urandom_range(0, 60);
    n = $urandom_range(15, 60);
    for (int i = 0; i < n; i++)
      send(OP_WRITE, $urandom_range(0, NTILES - 1), $urandom_range(0, 99) < dens,
           $urandom, $urandom);
    n = $urandom_range(0, 1);
    for (int j = 0; j <= n; j++) begin
      origin = $urandom_range(0, NTILES - 1);
      send(OP_RUN, origin, $urandom, pick_max(), pick_min());
      for (int i = $urandom_range(10, 30); i > 0; i--) begin
        case ($urandom_range(0, 19))
          0: send(OP_NONE, $urandom, $urandom, $urandom, $urandom);
          1: send(OP_WRITE, $urandom_range(0, NTILES - 1), $urandom, $urandom, $urandom);
          2, 3, 4: send(OP_READ, (origin + $urandom_range(0, 66) - 33) & (NTILES - 1),
                        $urandom, $urandom, $urandom);
          default: send(OP_READ, $urandom_range(0, NTILES - 1), $urandom,
                        $urandom, $urandom);
        endcase
      end
    end
  endtask

  // output side: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        for (int k = 0; k < 400; k++) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rcv_idle);
      end
    end
  end

  initial begin
    #40000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: untouched tiles, extremes, wall origins, unused code
    send(OP_READ, 0, 1'b0, 0, 0);
    send(OP_READ, NTILES - 1, 1'b1, -1, 10'h3FF);
    send(OP_NONE, NTILES - 1, 1'b1, -1, 10'h3FF);
    send(OP_WRITE, 0, 1'b1, 0, 0);
    send(OP_WRITE, NTILES - 1, 1'b1, -1, 10'h3FF);
    send(OP_WRITE, 5, 1'b0, 0, 0);
    send(OP_RUN, 0, 1'b0, -1, 0);
    send(OP_READ, 0, 1'b0, 0, 0);
    send(OP_READ, 1, 1'b0, 0, 0);
    send(OP_WRITE, 0, 1'b0, 0, 0);
    send(OP_RUN, NTILES - 1, 1'b0, 1023, 10'h3FF);
    send(OP_WRITE, NTILES - 1, 1'b0, 0, 0);
    send(OP_RUN, NTILES - 1, 1'b1, 1023, 0);
    send(OP_READ, 0, 1'b0, 0, 0);
    send(OP_READ, NTILES - 1, 1'b0, 0, 0);
    send(OP_RUN, 33, 1'b0, 5, 3);
    send(OP_READ, 36, 1'b0, 0, 0);
    send(OP_READ, 33, 1'b0, 0, 0);
    send(OP_RUN, 500, 1'b0, -2, 0);
    send(OP_READ, 501, 1'b0, 0, 0);
    send(OP_RUN, 10, 1'b0, 11'sh400, 10'h3FF);
    send(OP_READ, 10, 1'b0, 0, 0);
    send(OP_RUN, 700, 1'b0, -1, 10'h3FF);
    send(OP_READ, 0, 1'b0, 0, 0);
    drain();

    // receiver idles more than the sender, with a long output hold-off first
    snd_idle = 38;
    rcv_idle = 71;
    hold_req = 1'b1;
    for (int i = 0; i < 60; i++)
      send(OP_READ, $urandom_range(0, NTILES - 1), $urandom, $urandom, $urandom);
    while (sent < 560) random_segment();
    drain();

    snd_idle = 71;
    rcv_idle = 38;
    while (sent < 1100) random_segment();
    drain();

    snd_idle = 0;
    rcv_idle = 0;
    while (sent < 1630) random_segment();
    drain();
    repeat (64) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
